[rtl/core/symmetry_axis_search_assert.svh]
// Assertion macros for the symmetry axis search core.
// Included by the modules that check their own logic; no other dependencies.
`ifndef SYMMETRY_AXIS_SEARCH_ASSERT_SVH
`define SYMMETRY_AXIS_SEARCH_ASSERT_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is high.
`define SAS_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("assertion failed: lbl");
// Clocked check that also holds during reset.
`define SAS_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("assertion failed: lbl");
`else
`define SAS_ASSERT(lbl, clk_s, rst_s, prop)
`define SAS_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

[rtl/core/sas_pkg.sv]
// Shared types and constants of the symmetry axis search core.
// No dependencies; imported by the controller, datapath and top level.
package sas_pkg;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam int unsigned SHW_RESET   = 160;
  localparam logic [2:0]  ADDR_SHW    = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic push;
    logic start;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic direct;      // finish resolves without a scan
    logic last_issue;  // final read pair goes out this cycle
    logic out_busy;    // result register still holds an untaken result
  } sts_t;

endpackage

[rtl/core/sas_ctrl.sv]
// Controller of the symmetry axis search: request acceptance and scan sequencing.
// Depends on sas_pkg.
module sas_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          op,
  output logic          s_tready,
  input  sas_pkg::sts_t sts,
  output sas_pkg::cmd_t cmd
);
  import sas_pkg::*;

  state_t state, state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a finish waits while the previous result is still pending
  assign s_tready = (state == ST_IDLE) && !((op == OP_FINISH) && sts.out_busy);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (op == OP_FINISH) && !sts.direct) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (sts.last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.push  = accept && (op == OP_PUSH);
        cmd.start = accept && (op == OP_FINISH);
      end
      ST_RUN:   cmd.issue = 1'b1;
      ST_DRAIN: cmd = '0;
      default:  cmd = '0;
    endcase
  end

endmodule

[rtl/core/sas_datapath.sv]
// Datapath of the symmetry axis search: pixel store, scan counters, score
// accumulator, best tracker and result register. Depends on sas_pkg.
`include "symmetry_axis_search_assert.svh"
module sas_datapath #(
  parameter int MAX_BOX_WIDTH  = 256,
  parameter int MAX_BOX_HEIGHT = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  sas_pkg::cmd_t cmd,
  output sas_pkg::sts_t sts,
  input  logic [7:0]    pixel,
  input  logic [11:0]   box_left,
  input  logic [8:0]    box_width,
  input  logic [11:0]   shw,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          found,
  output logic [12:0]   axis_x,
  output logic [23:0]   min_score
);
  import sas_pkg::*;

  localparam int DEPTH = MAX_BOX_WIDTH * MAX_BOX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(MAX_BOX_WIDTH + 1);
  localparam int BW    = AW + 2;

  logic [7:0]    mem [DEPTH];
  logic [NW-1:0] count;
  // pixel count of the box under scan; count itself restarts at finish
  logic [NW-1:0] count_snap;

  logic [CW-1:0] w, steps, c, d;
  logic [11:0]   left;
  logic [BW-1:0] base;

  logic [CW-1:0] wsat, steps_in;
  logic [11:0]   shw_m1;
  logic          empty, trivial;

  logic          last_row, last_d, last_c;
  logic          va, vb;
  logic [BW-1:0] addr_a, addr_b;

  logic [7:0]    rd_a, rd_b;
  logic          s1_valid, s1_va, s1_vb, s1_last_col, s1_first_col, s1_last_all;
  logic [CW-1:0] s1_col;

  logic [23:0]   acc, acc_next, best_score, best_score_next;
  logic [CW-1:0] best_col, best_col_next;
  logic [7:0]    pa, pb, diff;
  logic [24:0]   sum;
  logic          take;

  // finish-time decode
  assign wsat = (32'(box_width) > MAX_BOX_WIDTH) ? CW'(MAX_BOX_WIDTH) : CW'(box_width);
  assign empty = (wsat == '0) || (32'(count) < 32'(wsat));
  assign shw_m1 = (shw == '0) ? 12'd0 : shw - 12'd1;
  assign steps_in = (32'(shw_m1) > 32'(wsat - CW'(1))) ? wsat - CW'(1) : CW'(shw_m1);
  assign trivial = (steps_in == '0);

  // scan position
  assign last_d   = (d == steps);
  assign last_row = (32'(base) + 32'(w) + 32'(w)) > 32'(count_snap);
  assign last_c   = (c == w - CW'(1));
  assign va       = (c >= d);
  assign vb       = (32'(c) + 32'(d)) < 32'(w);
  assign addr_a   = base + BW'(c) - BW'(d);
  assign addr_b   = base + BW'(c) + BW'(d);

  assign sts.direct     = empty || trivial;
  assign sts.last_issue = cmd.issue && last_d && last_row && last_c;
  assign sts.out_busy   = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.start) begin
      count <= '0;
    end else if (cmd.push && (32'(count) < DEPTH)) begin
      count <= count + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && (32'(count) < DEPTH)) begin
      mem[count[AW-1:0]] <= pixel;
    end
    rd_a <= mem[addr_a[AW-1:0]];
    rd_b <= mem[addr_b[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      w          <= wsat;
      left       <= box_left;
      steps      <= steps_in;
      count_snap <= count;
      c          <= '0;
      d          <= CW'(1);
      base       <= '0;
    end else if (cmd.issue) begin
      if (last_d) begin
        d <= CW'(1);
        if (last_row) begin
          base <= '0;
          c    <= c + CW'(1);
        end else begin
          base <= base + BW'(w);
        end
      end else begin
        d <= d + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s1_last_all <= 1'b0;
    end else begin
      s1_valid    <= cmd.issue;
      s1_last_all <= sts.last_issue;
    end
    s1_va        <= va;
    s1_vb        <= vb;
    s1_last_col  <= last_d && last_row;
    s1_first_col <= (c == '0);
    s1_col       <= c;
  end

  // accumulate one mirror pair, saturating at the score ceiling
  assign pa       = s1_va ? rd_a : 8'd0;
  assign pb       = s1_vb ? rd_b : 8'd0;
  assign diff     = (pa > pb) ? pa - pb : pb - pa;
  assign sum      = {1'b0, acc} + {17'd0, diff};
  assign acc_next = sum[24] ? 24'hFFFFFF : sum[23:0];
  assign take     = s1_valid && s1_last_col && (s1_first_col || (acc_next < best_score));
  assign best_score_next = take ? acc_next : best_score;
  assign best_col_next   = take ? s1_col : best_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      best_score <= '0;
      best_col   <= '0;
    end else begin
      if (cmd.start || (s1_valid && s1_last_col)) begin
        acc <= '0;
      end else if (s1_valid) begin
        acc <= acc_next;
      end
      best_score <= best_score_next;
      best_col   <= best_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.start && (empty || trivial)) || s1_last_all) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && (empty || trivial)) begin
      found     <= !empty;
      axis_x    <= empty ? 13'd0 : {1'b0, box_left};
      min_score <= '0;
    end else if (s1_last_all) begin
      found     <= 1'b1;
      axis_x    <= {1'b0, left} + 13'(best_col_next);
      min_score <= best_score_next;
    end
  end

  `SAS_ASSERT(a_no_push_in_scan, clk, rst, cmd.issue |-> !cmd.push && !cmd.start)
  `SAS_ASSERT(a_read_in_box, clk, rst, (cmd.issue && vb) |-> (32'(addr_b) < 32'(count_snap)))
  `SAS_ASSERT(a_scan_ends_in_result, clk, rst, s1_last_all |=> out_valid)
  `SAS_ASSERT(a_empty_is_zero, clk, rst, (out_valid && !found) |-> (min_score == 24'd0))

endmodule

[rtl/core/symmetry_axis_search.sv]
// Top level of the symmetry axis search core: stream ports, APB register,
// controller and datapath. Depends on sas_pkg, sas_ctrl, sas_datapath.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------
//  s_axis  | in  | s_tvalid / s_tready    | s_tuser op, s_tdata pixel/box
//  m_axis  | out | m_tvalid / m_tready    | m_tuser found, m_tdata axis/score
//  apb     | in  | psel penable pwrite    | paddr, pwdata, prdata
//
// Pixels stream in at one per cycle while the controller is idle.
// A finish with an empty box or no mirror distances answers in the cycle after it is
// taken; otherwise the scan runs over every column, row and distance, one pixel pair a
// cycle through the two read ports of the pixel store.
// Pushes are taken while a result waits; a finish waits until it is taken.
// Synchronous reset; the pixel store needs no clearing.
module symmetry_axis_search #(
  parameter int MAX_BOX_WIDTH  = 256,
  parameter int MAX_BOX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [7:0] pixel, [19:8] box_left, [28:20] box_width
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [12:0] axis_x, [36:13] min_score
  output logic        m_tuser,   // [0] found
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sas_pkg::*;

  logic [11:0] shw;
  cmd_t        cmd;
  sts_t        sts;
  logic [12:0] axis_x;
  logic [23:0] min_score;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SHW) ? {20'd0, shw} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      shw <= 12'(SHW_RESET);
    end else if (psel && penable && pwrite && (paddr == ADDR_SHW)) begin
      shw <= pwdata[11:0];
    end
  end

  sas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sas_datapath #(
    .MAX_BOX_WIDTH  (MAX_BOX_WIDTH),
    .MAX_BOX_HEIGHT (MAX_BOX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .pixel     (s_tdata[7:0]),
    .box_left  (s_tdata[19:8]),
    .box_width (s_tdata[28:20]),
    .shw       (shw),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .found     (m_tuser),
    .axis_x    (axis_x),
    .min_score (min_score)
  );

  assign m_tdata = {3'd0, min_score, axis_x};

endmodule

[tb/sv/tb_symmetry_axis_search.sv]
// Self-checking testbench for symmetry_axis_search: directed table with a full-width
// box, then random boxes under several half-width settings. Depends on sas_pkg and the RTL.
module tb_symmetry_axis_search;
  import sas_pkg::*;

  localparam int BOX_W = 256;
  localparam int DEPTH = 256 * 256;
  localparam int SCORE_SAT = 24'hFFFFFF;

  typedef struct packed {
    logic        found;
    logic [12:0] axis;
    logic [23:0] score;
  } axis_t;

  typedef struct {
    logic        op;
    logic [7:0]  pix;
    logic [11:0] left;
    logic [8:0]  width;
    bit          typed;
    axis_t       want;
  } row_t;

  logic        clk = 0, rst = 1;
  logic        s_tvalid = 0, s_tuser = 0, m_tready = 0;
  logic [31:0] s_tdata = 0;
  logic        s_tready, m_tvalid, m_tuser, pready;
  logic [39:0] m_tdata;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  symmetry_axis_search DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor state
  logic [7:0]  pix_store [DEPTH];
  int          held;
  int unsigned half_w;
  axis_t       pending [$];
  int          errors;
  bit          steady;
  int          sent;

  function automatic axis_t search_box(logic [11:0] left, logic [8:0] width);
    axis_t r;
    int w, rows, steps, a, b;
    longint sum, best;
    int best_c;
    w = (width > BOX_W) ? BOX_W : width;
    rows = (w == 0) ? 0 : held / w;
    held = 0;
    r.found = 0; r.axis = 0; r.score = 0;
    if (rows == 0) return r;
    steps = (half_w > 0) ? half_w - 1 : 0;
    if (steps > w - 1) steps = w - 1;
    best = 0; best_c = 0;
    for (int c = 0; c < w; c++) begin
      sum = 0;
      for (int rr = 0; rr < rows; rr++)
        for (int d = 1; d <= steps; d++) begin
          a = (c - d >= 0) ? pix_store[rr * w + c - d] : 0;
          b = (c + d < w) ? pix_store[rr * w + c + d] : 0;
          sum += (a > b) ? a - b : b - a;
        end
      if (sum > SCORE_SAT) sum = SCORE_SAT;
      if (c == 0 || sum < best) begin
        best = sum;
        best_c = c;
      end
    end
    r.found = 1;
    r.axis = 13'(left + best_c);
    r.score = best[23:0];
    return r;
  endfunction

  // s_tvalid stays up after an accept so a zero gap gives back-to-back requests
  task automatic send(logic op, logic [7:0] pix, logic [11:0] left, logic [8:0] width,
                      bit typed = 0, axis_t want = '{0, 0, 0});
    axis_t got;
    int gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 0;
    end
    @(negedge clk);
    s_tvalid = 1;
    s_tuser = op;
    s_tdata = {3'b0, width, left, pix};
    do @(posedge clk); while (!s_tready);
    if (op == OP_PUSH) begin
      if (held < DEPTH) begin
        pix_store[held] = pix;
        held++;
      end
    end else begin
      got = search_box(left, width);
      if (typed && got != want) begin
        $error("predictor disagrees with typed row: width %0d", width);
        errors++;
      end
      pending.insert(pending.size(), typed ? want : got);
    end
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_half_width(logic [11:0] v);
    @(negedge clk);
    psel = 1; pwrite = 1; paddr = ADDR_SHW; pwdata = 32'(v);
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    half_w = v;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // result side: random stall per request, checked against the oldest expectation
  initial begin
    axis_t e;
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
        @(negedge clk);
        m_tready = 0;
      end
      @(negedge clk);
      m_tready = 1;
      do @(posedge clk); while (!m_tvalid);
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending.pop_front();
        if (m_tuser !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, m_tuser);
          errors++;
        end
        if (m_tdata[12:0] !== e.axis) begin
          $error("axis_x: expected %0d, got %0d", e.axis, m_tdata[12:0]);
          errors++;
        end
        if (m_tdata[36:13] !== e.score) begin
          $error("min_score: expected %0d, got %0d", e.score, m_tdata[36:13]);
          errors++;
        end
      end
    end
  end

  initial begin
    #(8 * 4_000_000);
    $display("FAIL symmetry_axis_search");
    $finish;
  end

  row_t dir [$];
  int   shw_list [8] = '{2, 0, 1, 3, 7, 160, 2048, 5};

  initial begin
    int w, rows, extra, n;
    errors = 0; held = 0; half_w = SHW_RESET; sent = 0; steady = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // empty box right after reset
    dir.insert(dir.size(), '{OP_FINISH, 0, 12'd5, 9'd5, 1, '{0, 0, 0}});
    // two rows of 0,255: column 1 is a perfect mirror, axis past 12 bits
    dir.insert(dir.size(), '{OP_PUSH, 0, 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_PUSH, 255, 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_PUSH, 0, 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_PUSH, 255, 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_FINISH, 0, 12'd4095, 9'd2, 1, '{1, 13'd4096, 0}});
    // width zero with pixels held
    dir.insert(dir.size(), '{OP_PUSH, 7, 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_FINISH, 0, 12'd9, 9'd0, 1, '{0, 0, 0}});
    // only a partial row
    dir.insert(dir.size(), '{OP_PUSH, 1, 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_PUSH, 2, 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_FINISH, 0, 12'd3, 9'd3, 1, '{0, 0, 0}});
    // too wide saturates to 256, still no full row
    dir.insert(dir.size(), '{OP_PUSH, 10, 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_FINISH, 0, 12'd1, 9'd511, 1, '{0, 0, 0}});
    // one column: no distances
    dir.insert(dir.size(), '{OP_PUSH, 255, 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_FINISH, 0, 12'd0, 9'd1, 1, '{1, 0, 0}});
    // predictor-checked rows: 3-wide box, two rows and a partial tail
    for (int i = 0; i < 8; i++)
      dir.insert(dir.size(), '{OP_PUSH, 8'(i * 37), 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_FINISH, 0, 12'd2000, 9'd3, 0, '{0, 0, 0}});
    // one full row at the widest box, width given above the limit
    for (int i = 0; i < BOX_W; i++)
      dir.insert(dir.size(), '{OP_PUSH, 8'($urandom), 0, 0, 0, '{0, 0, 0}});
    dir.insert(dir.size(), '{OP_FINISH, 0, 12'd4000, 9'd300, 0, '{0, 0, 0}});
    foreach (dir[i]) send(dir[i].op, dir[i].pix, dir[i].left, dir[i].width,
                          dir[i].typed, dir[i].want);
    drain();

    foreach (shw_list[p]) begin
      write_half_width(12'(shw_list[p]));
      steady = ($urandom_range(0, 3) == 0);
      for (int b = 0; b < 3; b++) begin
        case ($urandom_range(0, 9))
          0: w = 0;
          1: w = $urandom_range(257, 511);
          2: w = 256;
          default: w = $urandom_range(1, 8);
        endcase
        rows = (w >= 256) ? 0 : $urandom_range(0, 3);
        extra = (w > 1 && w < 256) ? $urandom_range(0, w - 1) : 0;
        for (int i = 0; i < ((w >= 256) ? 256 : w) * rows + extra; i++)
          send(OP_PUSH, 8'($urandom), 12'($urandom), 9'($urandom));
        send(OP_FINISH, 8'($urandom), 12'($urandom), 9'(w));
      end
      drain();
    end
    steady = 0;
    write_half_width(SHW_RESET[11:0]);
    while (sent < 550) begin
      w = $urandom_range(1, 10);
      n = w * $urandom_range(1, 4) + $urandom_range(0, 2);
      for (int i = 0; i < n; i++)
        send(OP_PUSH, 8'($urandom), 0, 0);
      send(OP_FINISH, 0, 12'($urandom), 9'(w));
    end
    drain();

    if (errors == 0)
      $display("PASS symmetry_axis_search");
    else
      $display("FAIL symmetry_axis_search");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sas_pkg.sv
rtl/core/sas_ctrl.sv
rtl/core/sas_datapath.sv
rtl/core/symmetry_axis_search.sv
tb/sv/tb_symmetry_axis_search.sv
